FILE: src/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TPA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpa assertion failed");

// Next-cycle implication, checked during reset as well.
`define TPA_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tpa assertion failed");

`endif

FILE: src/tpa_pkg.sv
// Package for the tensor permute address generator: axis order, reset sizes,
// pipeline depths and the control struct. No dependencies.
`timescale 1ns / 1ps
package tpa_pkg;
   localparam int NDIM          = 8;
   localparam int DIM_IDX_BITS  = 3;
   localparam int CSR_IDX_BITS  = 4;
   localparam int PERM [NDIM]       = '{2, 5, 3, 6, 1, 0, 4, 7};
   localparam int SIZE_RESET [NDIM] = '{2, 3, 1, 2, 16, 1, 2, 16};
   // Stages an item waits at the front while the stride chain settles.
   localparam int FRONT_STAGES  = 9;
   localparam int MAC_STAGES    = 4;

   typedef struct packed {
      logic valid;
      logic oor;
   } ctl_type;
endpackage

FILE: src/tensor_permute_address_gen_unit.sv
// Top level of the tensor permute address generator: size registers, front
// delay, eight divider levels and the back end. Uses tpa_pkg, tpa_stride, tpa_level and tpa_mac.
`timescale 1ns / 1ps
//
//  channel  | ports                                   | flow
//  ---------+-----------------------------------------+-------------------------
//  request  | start, busy, req_dest_index             | taken when start && !busy
//  response | rsp_valid, rsp_source_index, rsp_out_.. | one cycle, no back pressure
//  csr      | csr_write_en, csr_index, csr_wdata      | taken when csr_write_en && csr_index < NDIM
//
// One word enters per cycle while busy is low. The front delay covers the stride
// multiply chain, each divider level spends one stage per quotient bit, and the
// back end is multiply plus adder tree. Reset is synchronous, loads the size
// registers with their reset values and clears all valid bits; busy is high
// only during reset. Nothing in the pipe ever stalls.
module tensor_permute_address_gen_unit #(
   parameter int INDEX_BITS = 31,
   parameter int DIM_BITS   = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [INDEX_BITS-1:0]             req_dest_index,
   input  logic                              csr_write_en,
   input  logic [tpa_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [DIM_BITS:0]                 csr_wdata,
   output logic                              rsp_valid,
   output logic [INDEX_BITS-1:0]             rsp_source_index,
   output logic                              rsp_out_of_range
);
   import tpa_pkg::*;

   localparam int CW = DIM_BITS + 1;
   localparam int NW = NDIM * CW;

   logic [CW-1:0]         size_ff [NDIM];
   logic                  dly_v_ff [FRONT_STAGES];
   logic [INDEX_BITS-1:0] dly_idx_ff [FRONT_STAGES];
   logic                  accept;

   logic [INDEX_BITS-1:0] orig_stride [NDIM];
   logic [INDEX_BITS:0]   perm_stride [NDIM];
   logic [INDEX_BITS:0]   total;

   ctl_type               lvl_ctl  [NDIM+1];
   logic [INDEX_BITS-1:0] lvl_rest [NDIM+1];
   logic [NW-1:0]         lvl_crd  [NDIM+1];

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NDIM; i++) size_ff[i] <= CW'(SIZE_RESET[i]);
      end else if (csr_write_en && (csr_index < CSR_IDX_BITS'(NDIM))) begin
         size_ff[csr_index[DIM_IDX_BITS-1:0]] <= csr_wdata;
      end
   end

   // Words wait here until strides and total derived from the sizes are settled.
   always_ff @(posedge clock) begin
      dly_idx_ff[0] <= req_dest_index;
      for (int j = 1; j < FRONT_STAGES; j++) dly_idx_ff[j] <= dly_idx_ff[j-1];
      if (reset) begin
         for (int j = 0; j < FRONT_STAGES; j++) dly_v_ff[j] <= 1'b0;
      end else begin
         dly_v_ff[0] <= accept;
         for (int j = 1; j < FRONT_STAGES; j++) dly_v_ff[j] <= dly_v_ff[j-1];
      end
   end

   tpa_stride #(.INDEX_BITS(INDEX_BITS), .DIM_BITS(DIM_BITS)) u_stride (
      .clock       (clock),
      .dim_size    (size_ff),
      .orig_stride (orig_stride),
      .perm_stride (perm_stride),
      .total       (total)
   );

   always_comb begin
      lvl_ctl[0].valid = dly_v_ff[FRONT_STAGES-1];
      lvl_ctl[0].oor   = {1'b0, dly_idx_ff[FRONT_STAGES-1]} >= total;
      lvl_rest[0]      = dly_idx_ff[FRONT_STAGES-1];
      lvl_crd[0]       = '0;
   end

   for (genvar g = 0; g < NDIM; g++) begin : g_level
      tpa_level #(.INDEX_BITS(INDEX_BITS), .DIM_BITS(DIM_BITS), .LEVEL(g)) u_level (
         .clock      (clock),
         .reset      (reset),
         .divisor    (perm_stride[g]),
         .in_ctl     (lvl_ctl[g]),
         .in_rest    (lvl_rest[g]),
         .in_coords  (lvl_crd[g]),
         .out_ctl    (lvl_ctl[g+1]),
         .out_rest   (lvl_rest[g+1]),
         .out_coords (lvl_crd[g+1])
      );
   end

   tpa_mac #(.INDEX_BITS(INDEX_BITS), .DIM_BITS(DIM_BITS)) u_mac (
      .clock            (clock),
      .reset            (reset),
      .in_ctl           (lvl_ctl[NDIM]),
      .in_coords        (lvl_crd[NDIM]),
      .orig_stride      (orig_stride),
      .rsp_valid        (rsp_valid),
      .rsp_source_index (rsp_source_index),
      .rsp_out_of_range (rsp_out_of_range)
   );
endmodule

FILE: src/tpa_stride.sv
// Stride unit: registered chain of saturating multiplies that turns the size
// registers into original strides, permuted strides and the total. Uses tpa_pkg.
`timescale 1ns / 1ps
module tpa_stride #(
   parameter int INDEX_BITS = 31,
   parameter int DIM_BITS   = 12
) (
   input  logic                  clock,
   input  logic [DIM_BITS:0]     dim_size  [tpa_pkg::NDIM],
   output logic [INDEX_BITS-1:0] orig_stride [tpa_pkg::NDIM],
   output logic [INDEX_BITS:0]   perm_stride [tpa_pkg::NDIM],
   output logic [INDEX_BITS:0]   total
);
   import tpa_pkg::*;

   localparam int SW = INDEX_BITS + 1;
   localparam int CW = DIM_BITS + 1;
   localparam int PW = SW + CW;
   localparam logic [SW-1:0] CAP = {1'b1, {INDEX_BITS{1'b0}}};
   localparam logic [SW-1:0] ONE = SW'(1);

   logic [SW-1:0] ostr_ff [NDIM-1];
   logic [SW-1:0] pstr_ff [NDIM-1];
   logic [SW-1:0] tot_ff;

   function automatic logic [SW-1:0] sat_mul(input logic [SW-1:0] a, input logic [CW-1:0] b);
      logic [PW-1:0] p;
      p = PW'(a) * PW'(b);
      return (p > PW'(CAP)) ? CAP : p[SW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      ostr_ff[NDIM-2] <= sat_mul(ONE, dim_size[NDIM-1]);
      pstr_ff[NDIM-2] <= sat_mul(ONE, dim_size[PERM[NDIM-1]]);
      for (int i = 0; i < NDIM - 2; i++) begin
         ostr_ff[i] <= sat_mul(ostr_ff[i+1], dim_size[i+1]);
         pstr_ff[i] <= sat_mul(pstr_ff[i+1], dim_size[PERM[i+1]]);
      end
      tot_ff <= sat_mul(pstr_ff[0], dim_size[PERM[0]]);
   end

   // A saturated original stride is 2^INDEX_BITS, which adds nothing modulo the index width.
   always_comb begin
      for (int i = 0; i < NDIM - 1; i++) begin
         orig_stride[i] = ostr_ff[i][INDEX_BITS-1:0];
         perm_stride[i] = pstr_ff[i];
      end
      orig_stride[NDIM-1] = INDEX_BITS'(1);
      perm_stride[NDIM-1] = ONE;
   end

   assign total = tot_ff;
endmodule

FILE: src/tpa_level.sv
// One coordinate level: a restoring divider with one quotient bit per stage
// that peels one coordinate off the remaining index. Uses tpa_pkg.
`timescale 1ns / 1ps
module tpa_level #(
   parameter int INDEX_BITS = 31,
   parameter int DIM_BITS   = 12,
   parameter int LEVEL      = 0
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [INDEX_BITS:0]                      divisor,
   input  tpa_pkg::ctl_type                         in_ctl,
   input  logic [INDEX_BITS-1:0]                    in_rest,
   input  logic [tpa_pkg::NDIM*(DIM_BITS+1)-1:0]    in_coords,
   output tpa_pkg::ctl_type                         out_ctl,
   output logic [INDEX_BITS-1:0]                    out_rest,
   output logic [tpa_pkg::NDIM*(DIM_BITS+1)-1:0]    out_coords
);
   import tpa_pkg::*;

   localparam int CW = DIM_BITS + 1;
   localparam int RW = INDEX_BITS + 1 + CW;
   localparam int NW = NDIM * CW;

   ctl_type               ctl_ff  [CW];
   logic [INDEX_BITS-1:0] rest_ff [CW];
   logic [NW-1:0]         crd_ff  [CW];

   ctl_type               src_ctl  [CW];
   logic [INDEX_BITS-1:0] src_rest [CW];
   logic [NW-1:0]         src_crd  [CW];
   logic [RW-1:0]         trial    [CW];
   logic                  ge       [CW];
   logic [RW-1:0]         diff     [CW];
   logic [INDEX_BITS-1:0] rest_in  [CW];
   logic [NW-1:0]         crd_in   [CW];

   // Stage k decides quotient bit CW-1-k by a trial subtract of the shifted divisor.
   always_comb begin
      for (int k = 0; k < CW; k++) begin
         if (k == 0) begin
            src_ctl[k]  = in_ctl;
            src_rest[k] = in_rest;
            src_crd[k]  = in_coords;
         end else begin
            src_ctl[k]  = ctl_ff[k-1];
            src_rest[k] = rest_ff[k-1];
            src_crd[k]  = crd_ff[k-1];
         end
         trial[k]   = RW'(divisor) << (CW - 1 - k);
         ge[k]      = RW'(src_rest[k]) >= trial[k];
         diff[k]    = RW'(src_rest[k]) - trial[k];
         rest_in[k] = ge[k] ? diff[k][INDEX_BITS-1:0] : src_rest[k];
         crd_in[k]  = src_crd[k] | (ge[k] ? (NW'(1) << (LEVEL * CW + CW - 1 - k)) : '0);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < CW; k++) begin
         rest_ff[k] <= rest_in[k];
         crd_ff[k]  <= crd_in[k];
      end
      if (reset) begin
         for (int k = 0; k < CW; k++) ctl_ff[k] <= '0;
      end else begin
         for (int k = 0; k < CW; k++) ctl_ff[k] <= src_ctl[k];
      end
   end

   assign out_ctl    = ctl_ff[CW-1];
   assign out_rest   = rest_ff[CW-1];
   assign out_coords = crd_ff[CW-1];
endmodule

FILE: src/tpa_mac.sv
// Multiply-accumulate back end: coordinate times original stride in eight
// lanes, then a registered adder tree and the output register. Uses tpa_pkg.
`timescale 1ns / 1ps
module tpa_mac #(
   parameter int INDEX_BITS = 31,
   parameter int DIM_BITS   = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tpa_pkg::ctl_type                      in_ctl,
   input  logic [tpa_pkg::NDIM*(DIM_BITS+1)-1:0] in_coords,
   input  logic [INDEX_BITS-1:0]                 orig_stride [tpa_pkg::NDIM],
   output logic                                  rsp_valid,
   output logic [INDEX_BITS-1:0]                 rsp_source_index,
   output logic                                  rsp_out_of_range
);
   import tpa_pkg::*;

   localparam int CW = DIM_BITS + 1;
   localparam int MW = CW + INDEX_BITS;

   logic [MW-1:0]         full [NDIM];
   logic [INDEX_BITS-1:0] prod_ff [NDIM];
   logic [INDEX_BITS-1:0] sum4_ff [NDIM/2];
   logic [INDEX_BITS-1:0] sum2_ff [NDIM/4];
   logic [INDEX_BITS-1:0] sum_in;
   ctl_type               ctl1_ff, ctl2_ff, ctl3_ff;
   logic                  valid_ff, oor_ff;
   logic [INDEX_BITS-1:0] src_ff;

   // Output coordinate i belongs to original axis PERM[i].
   always_comb begin
      for (int i = 0; i < NDIM; i++) begin
         full[i] = MW'(in_coords[i*CW +: CW]) * MW'(orig_stride[PERM[i]]);
      end
      sum_in = sum2_ff[0] + sum2_ff[1];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NDIM; i++) prod_ff[i] <= full[i][INDEX_BITS-1:0];
      for (int i = 0; i < NDIM / 2; i++) sum4_ff[i] <= prod_ff[2*i] + prod_ff[2*i+1];
      for (int i = 0; i < NDIM / 4; i++) sum2_ff[i] <= sum4_ff[2*i] + sum4_ff[2*i+1];
      src_ff <= ctl3_ff.oor ? '0 : sum_in;
      oor_ff <= ctl3_ff.oor;
      if (reset) begin
         ctl1_ff  <= '0;
         ctl2_ff  <= '0;
         ctl3_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         ctl1_ff  <= in_ctl;
         ctl2_ff  <= ctl1_ff;
         ctl3_ff  <= ctl2_ff;
         valid_ff <= ctl3_ff.valid;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_source_index = src_ff;
   assign rsp_out_of_range = oor_ff;
endmodule

FILE: src/tpa_checker.sv
// Port-level checker for the tensor permute address generator, bound to the top.
// Uses tpa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tpa_checker #(
   parameter int INDEX_BITS = 31,
   parameter int DIM_BITS   = 12
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic [INDEX_BITS-1:0]            req_dest_index,
   input logic                             rsp_valid,
   input logic [INDEX_BITS-1:0]            rsp_source_index,
   input logic                             rsp_out_of_range
);
   import tpa_pkg::*;

   localparam int LAT = FRONT_STAGES + NDIM * (DIM_BITS + 1) + MAC_STAGES;

   // Every response traces back to a word taken a fixed latency earlier.
   `TPA_ASSERT_IMPLY(a_rsp_has_req, clock, reset, rsp_valid, $past(start && !busy, LAT))
   `TPA_ASSERT_IMPLY(a_oor_zero, clock, reset, rsp_valid && rsp_out_of_range, rsp_source_index == '0)
   // Index zero maps to source zero whenever it is in range.
   `TPA_ASSERT_IMPLY(a_zero_maps_zero, clock, reset,
      rsp_valid && !rsp_out_of_range && $past(start && !busy && req_dest_index == '0, LAT),
      rsp_source_index == '0)
   `TPA_ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_valid)
endmodule

bind tensor_permute_address_gen_unit tpa_checker #(
   .INDEX_BITS(INDEX_BITS),
   .DIM_BITS(DIM_BITS)
) u_tpa_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_dest_index   (req_dest_index),
   .rsp_valid        (rsp_valid),
   .rsp_source_index (rsp_source_index),
   .rsp_out_of_range (rsp_out_of_range)
);

FILE: sim/testbench.sv
// Self-checking testbench for tensor_permute_address_gen_unit: predicts the source
// index of every destination index from its own copy of the size registers.
// Depends on tpa_pkg and the RTL of the block.
`timescale 1ns / 1ps
module testbench;
   import tpa_pkg::*;

   localparam int IDX_W     = 31;
   localparam int SIZE_W    = 13;
   localparam logic [63:0] SAT_LIMIT = 64'd1 << IDX_W;
   localparam int LATENCY   = 9 + 8 * SIZE_W + 4;
   localparam int CYCLE_CAP = 400000;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIM3      = CSR_IDX_BITS'(3);
   localparam logic [CSR_IDX_BITS-1:0] CSR_LAST_DIM  = CSR_IDX_BITS'(NDIM - 1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAST_LAST = CSR_IDX_BITS'(NDIM);
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED  = 4'hF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [IDX_W-1:0] req_dest_index = '0;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [SIZE_W-1:0] csr_wdata = '0;
   logic rsp_valid;
   logic [IDX_W-1:0] rsp_source_index;
   logic rsp_out_of_range;

   typedef struct {
      logic [IDX_W-1:0] source_index;
      logic             out_of_range;
   } source_word_type;

   logic [SIZE_W-1:0] dim_size [NDIM];
   source_word_type   pending_sources [$];
   int                error_count = 0;
   int                cycle_count = 0;

   tensor_permute_address_gen_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_dest_index(req_dest_index), .csr_write_en(csr_write_en),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .rsp_valid(rsp_valid),
      .rsp_source_index(rsp_source_index), .rsp_out_of_range(rsp_out_of_range)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("tensor_permute_address_gen_unit test failed");
         $finish;
      end
   end

   function automatic logic [63:0] sat_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return (p > 128'(SAT_LIMIT)) ? SAT_LIMIT : p[63:0];
   endfunction

   // Number of elements, saturated at 2^31 like the strides.
   function automatic logic [63:0] element_count();
      logic [63:0] n;
      n = 64'd1;
      for (int i = 0; i < NDIM; i++) n = sat_mul(n, 64'(dim_size[i]));
      return n;
   endfunction

   function automatic source_word_type gather_source(input logic [IDX_W-1:0] dest);
      logic [63:0] orig_stride [NDIM];
      logic [63:0] perm_stride [NDIM];
      logic [63:0] total, rest, coord, sum;
      source_word_type w;
      orig_stride[NDIM-1] = 64'd1;
      perm_stride[NDIM-1] = 64'd1;
      for (int i = NDIM - 2; i >= 0; i--) begin
         orig_stride[i] = sat_mul(orig_stride[i+1], 64'(dim_size[i+1]));
         perm_stride[i] = sat_mul(perm_stride[i+1], 64'(dim_size[PERM[i+1]]));
      end
      total = sat_mul(perm_stride[0], 64'(dim_size[PERM[0]]));
      if (64'(dest) >= total) begin
         w.source_index = '0;
         w.out_of_range = 1'b1;
         return w;
      end
      rest = 64'(dest);
      sum = '0;
      for (int i = 0; i < NDIM; i++) begin
         coord = rest / perm_stride[i];
         rest  = rest % perm_stride[i];
         sum   = sum + coord * orig_stride[PERM[i]];
      end
      w.source_index = sum[IDX_W-1:0];
      w.out_of_range = 1'b0;
      return w;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_sources.size() == 0) begin
            report_mismatch("unexpected word", 64'(rsp_source_index), 64'd0);
         end else begin
            source_word_type w;
            w = pending_sources.pop_front();
            if (rsp_source_index !== w.source_index)
               report_mismatch("source_index", 64'(rsp_source_index),
                               64'(w.source_index));
            if (rsp_out_of_range !== w.out_of_range)
               report_mismatch("out_of_range", 64'(rsp_out_of_range),
                               64'(w.out_of_range));
         end
      end
   end

   // Sends one word after a random gap; start stays high into the next call.
   task automatic send_index(input logic [IDX_W-1:0] dest);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_dest_index <= dest;
      while (busy) @(negedge clock);
      @(posedge clock);
      pending_sources.push_back(gather_source(dest));
   endtask

   // Lets the pipe empty, so registers can be written safely.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_sources.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_size(input logic [CSR_IDX_BITS-1:0] idx,
                             input logic [SIZE_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx <= CSR_LAST_DIM) dim_size[idx] = value;
   endtask

   task automatic write_all_sizes(input logic [SIZE_W-1:0] value);
      for (int i = 0; i < NDIM; i++) write_size(CSR_IDX_BITS'(i), value);
      repeat (20) @(negedge clock);
   endtask

   task automatic test_reset_sizes();
      send_index(0);
      send_index(6143);
      send_index(6144);
      send_index({IDX_W{1'b1}});
      send_index(31'h2AAA_AAAA);
      send_index(31'h5555_5555);
      for (int i = 0; i < 6; i++) send_index(IDX_W'($urandom_range(0, 6143)));
      drain();
   endtask

   task automatic test_extreme_sizes();
      write_all_sizes(1);
      send_index(0);
      send_index(1);
      drain();
      write_all_sizes(4096);    // product saturates: nothing is out of range
      send_index(0);
      send_index({IDX_W{1'b1}});
      send_index(IDX_W'($urandom));
      drain();
      write_all_sizes(8191);
      send_index({IDX_W{1'b1}});
      send_index(12345);
      drain();
      write_all_sizes(1);
      write_size(CSR_DIM3, 0);  // a zero size leaves no valid index
      send_index(0);
      send_index(7);
      drain();
   endtask

   task automatic test_unmapped_register();
      write_all_sizes(2);
      write_size(CSR_UNMAPPED, 0);
      write_size(CSR_PAST_LAST, 0);
      repeat (20) @(negedge clock);
      send_index(255);
      send_index(256);
      drain();
   endtask

   task automatic test_random_shapes(input int phases, input int per_phase);
      logic [63:0] n;
      for (int p = 0; p < phases; p++) begin
         for (int i = 0; i < NDIM; i++)
            write_size(CSR_IDX_BITS'(i),
                       SIZE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 4096)
                                                           : $urandom_range(1, 6)));
         repeat (20) @(negedge clock);
         n = element_count();
         for (int k = 0; k < per_phase; k++) begin
            if ($urandom_range(0, 9) == 0 || n >= SAT_LIMIT)
               send_index(IDX_W'($urandom));
            else if ($urandom_range(0, 19) == 0)
               send_index(IDX_W'(n - 64'd1 + 64'($urandom_range(0, 2))));
            else
               send_index(IDX_W'($urandom_range(0, 32'(n - 64'd1))));
         end
         drain();
      end
   endtask

   initial begin
      for (int i = 0; i < NDIM; i++) dim_size[i] = SIZE_W'(SIZE_RESET[i]);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_sizes();
      test_extreme_sizes();
      test_unmapped_register();
      test_random_shapes(8, 204);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0)
         $display("tensor_permute_address_gen_unit test passed");
      else
         $display("tensor_permute_address_gen_unit test failed");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+src
src/tpa_pkg.sv
src/tpa_stride.sv
src/tpa_level.sv
src/tpa_mac.sv
src/tensor_permute_address_gen_unit.sv
src/tpa_checker.sv
sim/testbench.sv
